@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/oblend_pkg.sv @@
`default_nettype none

package oblend_pkg;

   // Widths of the pixel arithmetic.
   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned SHIFT_W   = 5;
   localparam int unsigned NUM_CHAN  = 3;
   localparam int unsigned PROD_W    = 16;
   localparam int unsigned TERM_W    = 24;
   localparam int unsigned NUM_W     = 17;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   // Reciprocal of 255 scaled by two to the 31st. Exact for any value below
   // about 16.9 million, which covers every term that is divided here.
   localparam logic [TERM_W-1:0] RECIP_255   = 24'h808081;
   localparam int unsigned       RECIP_SHIFT = 31;

   // Quotient bits resolved by each divider stage.
   localparam int unsigned DIV_STEPS_DEFAULT = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RED_SHIFT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_SHIFT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_SHIFT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_SHIFT = 2'd3;

   // How the result pixel is formed.
   typedef enum logic [1:0] {
      MODE_BLEND  = 2'd0,
      MODE_SOURCE = 2'd1,
      MODE_DEST   = 2'd2
   } mode_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] red;
      logic [SHIFT_W-1:0] green;
      logic [SHIFT_W-1:0] blue;
      logic [SHIFT_W-1:0] alpha;
   } shifts_type;

   localparam shifts_type SHIFTS_RESET = '{red: 5'd0, green: 5'd8, blue: 5'd16, alpha: 5'd24};

   // Side information that travels with a pixel through the divider.
   typedef struct packed {
      mode_type          mode;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } bypass_type;

   localparam int unsigned TAG_W = $bits(bypass_type);

   // Picks one byte out of the source word.
   function automatic logic [CHAN_W-1:0] take_byte(input logic [31:0] word,
                                                   input logic [SHIFT_W-1:0] shift);
      logic [31:0] shifted;
      shifted = word >> shift;
      return shifted[CHAN_W-1:0];
   endfunction

   // Exact division by 255 through a reciprocal multiplication.
   function automatic logic [PROD_W-1:0] div_by_255(input logic [TERM_W-1:0] x);
      logic [2*TERM_W-1:0] prod;
      prod = (2*TERM_W)'(x) * (2*TERM_W)'(RECIP_255);
      return prod[RECIP_SHIFT +: PROD_W];
   endfunction

endpackage

`default_nettype wire

@@ rtl/oblend_front.sv @@
`default_nettype none

module oblend_front (
   input  wire logic                                                     clock,
   input  wire logic                                                     reset,
   input  wire logic                                                     in_valid,
   input  wire logic [31:0]                                              source_word,
   input  wire logic [oblend_pkg::NUM_CHAN-1:0][oblend_pkg::CHAN_W-1:0]  dest_col,
   input  wire logic [oblend_pkg::CHAN_W-1:0]                            dest_alpha,
   input  wire oblend_pkg::shifts_type                                   shifts,
   output logic                                                          out_valid,
   output logic [oblend_pkg::NUM_CHAN-1:0][oblend_pkg::NUM_W-1:0]        out_num,
   output logic [oblend_pkg::CHAN_W-1:0]                                 out_alpha,
   output oblend_pkg::bypass_type                                        out_tag
);

   localparam int unsigned NumChan = oblend_pkg::NUM_CHAN;
   localparam int unsigned ChanW   = oblend_pkg::CHAN_W;
   localparam int unsigned ProdW   = oblend_pkg::PROD_W;
   localparam int unsigned TermW   = oblend_pkg::TERM_W;
   localparam int unsigned NumW    = oblend_pkg::NUM_W;

   // Stage A: extracted channels and the selected mode.
   logic                                a_valid_ff, a_valid_in;
   logic [NumChan-1:0][ChanW-1:0]       a_col_ff, a_col_in;
   logic [NumChan-1:0][ChanW-1:0]       a_dcol_ff;
   logic [ChanW-1:0]                    a_alpha_ff, a_alpha_in;
   logic [ChanW-1:0]                    a_dalpha_ff;
   oblend_pkg::bypass_type              a_tag_ff, a_tag_in;

   // Stage B: first products.
   logic                                b_valid_ff;
   logic [NumChan-1:0][ProdW-1:0]       b_ca_ff, b_ca_in;
   logic [NumChan-1:0][ProdW-1:0]       b_pd_ff, b_pd_in;
   logic [ChanW-1:0]                    b_inv_ff, b_inv_in;
   logic [ProdW-1:0]                    b_tda_ff, b_tda_in;
   logic [ChanW-1:0]                    b_alpha_ff;
   oblend_pkg::bypass_type              b_tag_ff;

   // Stage C: destination terms scaled by the inverse source alpha.
   logic                                c_valid_ff;
   logic [NumChan-1:0][ProdW-1:0]       c_ca_ff;
   logic [NumChan-1:0][TermW-1:0]       c_t_ff, c_t_in;
   logic [ChanW-1:0]                    c_tq_ff, c_tq_in;
   logic [ProdW-1:0]                    c_tq_full;
   logic [ChanW-1:0]                    c_alpha_ff;
   oblend_pkg::bypass_type              c_tag_ff;

   // Stage D: terms divided by 255 and the output alpha.
   logic                                d_valid_ff;
   logic [NumChan-1:0][ProdW-1:0]       d_ca_ff;
   logic [NumChan-1:0][ProdW-1:0]       d_dq_ff, d_dq_in;
   logic [ChanW-1:0]                    d_oa_ff, d_oa_in;
   logic [ChanW:0]                      d_oa_sum;
   oblend_pkg::bypass_type              d_tag_ff;

   // Stage E: colour numerators.
   logic                                e_valid_ff;
   logic [NumChan-1:0][NumW-1:0]        e_num_ff, e_num_in;
   logic [ChanW-1:0]                    e_oa_ff;
   oblend_pkg::bypass_type              e_tag_ff;

   // Channel extraction and the choice between blend, copy and keep.
   always_comb begin
      a_valid_in    = in_valid;
      a_col_in[0]   = oblend_pkg::take_byte(source_word, shifts.red);
      a_col_in[1]   = oblend_pkg::take_byte(source_word, shifts.green);
      a_col_in[2]   = oblend_pkg::take_byte(source_word, shifts.blue);
      a_alpha_in    = oblend_pkg::take_byte(source_word, shifts.alpha);
      a_tag_in.red   = dest_col[0];
      a_tag_in.green = dest_col[1];
      a_tag_in.blue  = dest_col[2];
      a_tag_in.alpha = dest_alpha;
      priority if (a_alpha_in == oblend_pkg::CHAN_MAX) begin
         a_tag_in.mode  = oblend_pkg::MODE_SOURCE;
         a_tag_in.red   = a_col_in[0];
         a_tag_in.green = a_col_in[1];
         a_tag_in.blue  = a_col_in[2];
         a_tag_in.alpha = a_alpha_in;
      end else if (a_alpha_in == '0) begin
         a_tag_in.mode = oblend_pkg::MODE_DEST;
      end else begin
         a_tag_in.mode = oblend_pkg::MODE_BLEND;
      end
   end

   // Source and destination products.
   always_comb begin
      b_inv_in = oblend_pkg::CHAN_MAX - a_alpha_ff;
      b_tda_in = ProdW'(a_dalpha_ff) * ProdW'(b_inv_in);
      for (int c = 0; c < NumChan; c++) begin
         b_ca_in[c] = ProdW'(a_col_ff[c]) * ProdW'(a_alpha_ff);
         b_pd_in[c] = ProdW'(a_dcol_ff[c]) * ProdW'(a_dalpha_ff);
      end
   end

   // Destination terms times the inverse alpha; alpha term divided by 255.
   always_comb begin
      c_tq_full = oblend_pkg::div_by_255(TermW'(b_tda_ff));
      c_tq_in   = c_tq_full[ChanW-1:0];
      for (int c = 0; c < NumChan; c++) begin
         c_t_in[c] = TermW'(b_pd_ff[c]) * TermW'(b_inv_ff);
      end
   end

   // Colour terms divided by 255; output alpha never exceeds 255.
   always_comb begin
      d_oa_sum = {1'b0, c_alpha_ff} + {1'b0, c_tq_ff};
      d_oa_in  = d_oa_sum[ChanW-1:0];
      for (int c = 0; c < NumChan; c++) begin
         d_dq_in[c] = oblend_pkg::div_by_255(c_t_ff[c]);
      end
   end

   // Numerators for the final division.
   always_comb begin
      for (int c = 0; c < NumChan; c++) begin
         e_num_in[c] = NumW'(d_ca_ff[c]) + NumW'(d_dq_ff[c]);
      end
   end

   // Valid bits of the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   // Payload of the stages.
   always_ff @(posedge clock) begin
      a_col_ff    <= a_col_in;
      a_dcol_ff   <= dest_col;
      a_alpha_ff  <= a_alpha_in;
      a_dalpha_ff <= dest_alpha;
      a_tag_ff    <= a_tag_in;

      b_ca_ff     <= b_ca_in;
      b_pd_ff     <= b_pd_in;
      b_inv_ff    <= b_inv_in;
      b_tda_ff    <= b_tda_in;
      b_alpha_ff  <= a_alpha_ff;
      b_tag_ff    <= a_tag_ff;

      c_ca_ff     <= b_ca_ff;
      c_t_ff      <= c_t_in;
      c_tq_ff     <= c_tq_in;
      c_alpha_ff  <= b_alpha_ff;
      c_tag_ff    <= b_tag_ff;

      d_ca_ff     <= c_ca_ff;
      d_dq_ff     <= d_dq_in;
      d_oa_ff     <= d_oa_in;
      d_tag_ff    <= c_tag_ff;

      e_num_ff    <= e_num_in;
      e_oa_ff     <= d_oa_ff;
      e_tag_ff    <= d_tag_ff;
   end

   assign out_valid = e_valid_ff;
   assign out_num   = e_num_ff;
   assign out_alpha = e_oa_ff;
   assign out_tag   = e_tag_ff;

endmodule

`default_nettype wire

@@ rtl/oblend_div.sv @@
`default_nettype none

module oblend_div #(
   parameter int unsigned StepsPerStage = oblend_pkg::DIV_STEPS_DEFAULT,
   parameter int unsigned TagW          = oblend_pkg::TAG_W
) (
   input  wire logic                                                     clock,
   input  wire logic                                                     reset,
   input  wire logic                                                     in_valid,
   input  wire logic [oblend_pkg::NUM_CHAN-1:0][oblend_pkg::NUM_W-1:0]   in_num,
   input  wire logic [oblend_pkg::CHAN_W-1:0]                            in_divisor,
   input  wire logic [TagW-1:0]                                          in_tag,
   output logic                                                          out_valid,
   output logic [oblend_pkg::NUM_CHAN-1:0][oblend_pkg::CHAN_W-1:0]       out_quot,
   output logic                                                          out_wrapped,
   output logic [oblend_pkg::CHAN_W-1:0]                                 out_divisor,
   output logic [TagW-1:0]                                               out_tag
);

   localparam int unsigned NumChan = oblend_pkg::NUM_CHAN;
   localparam int unsigned ChanW   = oblend_pkg::CHAN_W;
   localparam int unsigned NumW    = oblend_pkg::NUM_W;
   localparam int unsigned Stages  = (NumW + StepsPerStage - 1) / StepsPerStage;
   localparam int unsigned PadW    = Stages * StepsPerStage;

   // Partial remainder and the numerator, whose low end fills with quotient bits.
   typedef struct packed {
      logic [ChanW-1:0] rem;
      logic [PadW-1:0]  num;
   } work_type;

   logic                        valid_ff   [Stages];
   work_type [NumChan-1:0]      work_ff    [Stages];
   logic [ChanW-1:0]            divisor_ff [Stages];
   logic [TagW-1:0]             tag_ff     [Stages];

   logic [NumChan-1:0]          wrap_chan;

   // One restoring division step.
   function automatic work_type div_step(input work_type w, input logic [ChanW-1:0] d);
      work_type     r;
      logic [ChanW:0] rem_sh;
      logic [ChanW:0] diff;
      logic           qbit;
      rem_sh = {w.rem, w.num[PadW-1]};
      if (rem_sh >= {1'b0, d}) begin
         diff = rem_sh - {1'b0, d};
         qbit = 1'b1;
      end else begin
         diff = rem_sh;
         qbit = 1'b0;
      end
      r.rem = diff[ChanW-1:0];
      r.num = {w.num[PadW-2:0], qbit};
      return r;
   endfunction

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic                   valid_src;
      work_type [NumChan-1:0] work_src;
      work_type [NumChan-1:0] work_in;
      logic [ChanW-1:0]       divisor_src;
      logic [TagW-1:0]        tag_src;

      if (s == 0) begin : g_first
         assign valid_src   = in_valid;
         assign divisor_src = in_divisor;
         assign tag_src     = in_tag;
         always_comb begin
            for (int c = 0; c < NumChan; c++) begin
               work_src[c].rem = '0;
               work_src[c].num = PadW'(in_num[c]);
            end
         end
      end else begin : g_next
         assign valid_src   = valid_ff[s-1];
         assign divisor_src = divisor_ff[s-1];
         assign tag_src     = tag_ff[s-1];
         assign work_src    = work_ff[s-1];
      end

      // A few quotient bits per stage, all channels sharing the divisor.
      always_comb begin
         work_in = work_src;
         for (int c = 0; c < NumChan; c++) begin
            for (int k = 0; k < StepsPerStage; k++) begin
               work_in[c] = div_step(work_in[c], divisor_src);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         work_ff[s]    <= work_in;
         divisor_ff[s] <= divisor_src;
         tag_ff[s]     <= tag_src;
      end
   end

   // Low byte of each quotient, and whether any quotient ran past it.
   always_comb begin
      for (int c = 0; c < NumChan; c++) begin
         out_quot[c]  = work_ff[Stages-1][c].num[ChanW-1:0];
         wrap_chan[c] = |work_ff[Stages-1][c].num[PadW-1:ChanW];
      end
   end

   assign out_wrapped = |wrap_chan;
   assign out_valid   = valid_ff[Stages-1];
   assign out_divisor = divisor_ff[Stages-1];
   assign out_tag     = tag_ff[Stages-1];

endmodule

`default_nettype wire

@@ rtl/rgba_over_alpha_blend.sv @@
`default_nettype none

`include "assert_macros.svh"

// Straight-alpha "over" compositing of one packed source pixel onto one RGBA8
// destination pixel. A transaction is taken whenever start is high and busy is
// low; busy is only high during reset, so one pixel can be taken every cycle.
// Each result appears on the rsp_ ports for a single cycle with rsp_strobe high,
// in order, after passing through five stages of channel extraction, products
// and exact division by 255, one stage per group of quotient bits in the shared
// colour divider (three quotient bits per divider stage by default), and the
// output register. The receiver cannot hold results off, so it must take each
// strobe. Shift registers must be written by the user through the csr_ port only
// while no transaction is in flight; the block itself does not enforce this.
module rgba_over_alpha_blend #(
   parameter int unsigned DivStepsPerStage = oblend_pkg::DIV_STEPS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [31:0]                         req_source_word,
   input  wire logic [oblend_pkg::CHAN_W-1:0]       req_dest_red,
   input  wire logic [oblend_pkg::CHAN_W-1:0]       req_dest_green,
   input  wire logic [oblend_pkg::CHAN_W-1:0]       req_dest_blue,
   input  wire logic [oblend_pkg::CHAN_W-1:0]       req_dest_alpha,
   output logic                                     rsp_strobe,
   output logic [oblend_pkg::CHAN_W-1:0]            rsp_new_red,
   output logic [oblend_pkg::CHAN_W-1:0]            rsp_new_green,
   output logic [oblend_pkg::CHAN_W-1:0]            rsp_new_blue,
   output logic [oblend_pkg::CHAN_W-1:0]            rsp_new_alpha,
   output logic                                     rsp_channel_wrapped,
   input  wire logic                                csr_we,
   input  wire logic [oblend_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [oblend_pkg::SHIFT_W-1:0]      csr_wdata
);

   localparam int unsigned NumChan = oblend_pkg::NUM_CHAN;
   localparam int unsigned ChanW   = oblend_pkg::CHAN_W;
   localparam int unsigned NumW    = oblend_pkg::NUM_W;
   localparam int unsigned TagW    = oblend_pkg::TAG_W;

   oblend_pkg::shifts_type              shifts_ff, shifts_in;

   logic                                accept;
   logic [NumChan-1:0][ChanW-1:0]       dest_col;

   logic                                front_valid;
   logic [NumChan-1:0][NumW-1:0]        front_num;
   logic [ChanW-1:0]                    front_alpha;
   oblend_pkg::bypass_type              front_tag;

   logic                                div_valid;
   logic [NumChan-1:0][ChanW-1:0]       div_quot;
   logic                                div_wrapped;
   logic [ChanW-1:0]                    div_alpha;
   logic [TagW-1:0]                     div_tag_bits;
   oblend_pkg::bypass_type              div_tag;

   logic                                rsp_strobe_ff, rsp_strobe_in;
   logic [ChanW-1:0]                    rsp_red_ff, rsp_red_in;
   logic [ChanW-1:0]                    rsp_green_ff, rsp_green_in;
   logic [ChanW-1:0]                    rsp_blue_ff, rsp_blue_in;
   logic [ChanW-1:0]                    rsp_alpha_ff, rsp_alpha_in;
   logic                                rsp_wrapped_ff, rsp_wrapped_in;
   oblend_pkg::mode_type                rsp_mode_ff;

   // The pipeline never stalls; transactions are only refused during reset.
   assign busy   = reset;
   assign accept = start && !busy;

   // Channel shift registers.
   always_comb begin
      shifts_in = shifts_ff;
      if (csr_we) begin
         unique case (csr_index)
            oblend_pkg::CSR_RED_SHIFT:   shifts_in.red   = csr_wdata;
            oblend_pkg::CSR_GREEN_SHIFT: shifts_in.green = csr_wdata;
            oblend_pkg::CSR_BLUE_SHIFT:  shifts_in.blue  = csr_wdata;
            oblend_pkg::CSR_ALPHA_SHIFT: shifts_in.alpha = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shifts_ff <= oblend_pkg::SHIFTS_RESET;
      end else begin
         shifts_ff <= shifts_in;
      end
   end

   assign dest_col[0] = req_dest_red;
   assign dest_col[1] = req_dest_green;
   assign dest_col[2] = req_dest_blue;

   oblend_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .source_word (req_source_word),
      .dest_col    (dest_col),
      .dest_alpha  (req_dest_alpha),
      .shifts      (shifts_ff),
      .out_valid   (front_valid),
      .out_num     (front_num),
      .out_alpha   (front_alpha),
      .out_tag     (front_tag)
   );

   oblend_div #(
      .StepsPerStage (DivStepsPerStage),
      .TagW          (TagW)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (front_valid),
      .in_num      (front_num),
      .in_divisor  (front_alpha),
      .in_tag      (front_tag),
      .out_valid   (div_valid),
      .out_quot    (div_quot),
      .out_wrapped (div_wrapped),
      .out_divisor (div_alpha),
      .out_tag     (div_tag_bits)
   );

   assign div_tag = oblend_pkg::bypass_type'(div_tag_bits);

   // Result selection: blended pixel, or a copied source or destination.
   always_comb begin
      rsp_strobe_in = div_valid;
      unique case (div_tag.mode)
         oblend_pkg::MODE_BLEND: begin
            rsp_red_in     = div_quot[0];
            rsp_green_in   = div_quot[1];
            rsp_blue_in    = div_quot[2];
            rsp_alpha_in   = div_alpha;
            rsp_wrapped_in = div_wrapped;
         end
         oblend_pkg::MODE_SOURCE, oblend_pkg::MODE_DEST: begin
            rsp_red_in     = div_tag.red;
            rsp_green_in   = div_tag.green;
            rsp_blue_in    = div_tag.blue;
            rsp_alpha_in   = div_tag.alpha;
            rsp_wrapped_in = 1'b0;
         end
         default: begin
            rsp_red_in     = '0;
            rsp_green_in   = '0;
            rsp_blue_in    = '0;
            rsp_alpha_in   = '0;
            rsp_wrapped_in = 1'b0;
         end
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_red_ff     <= rsp_red_in;
      rsp_green_ff   <= rsp_green_in;
      rsp_blue_ff    <= rsp_blue_in;
      rsp_alpha_ff   <= rsp_alpha_in;
      rsp_wrapped_ff <= rsp_wrapped_in;
      rsp_mode_ff    <= div_tag.mode;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_new_red         = rsp_red_ff;
   assign rsp_new_green       = rsp_green_ff;
   assign rsp_new_blue        = rsp_blue_ff;
   assign rsp_new_alpha       = rsp_alpha_ff;
   assign rsp_channel_wrapped = rsp_wrapped_ff;

   // A blended pixel always has a source alpha of at least one, so its divisor is never zero.
   `ASSERT_IMPLIES(a_blend_divisor_nonzero, clock, reset, front_valid && (front_tag.mode == oblend_pkg::MODE_BLEND), front_alpha != '0, "blend divisor is zero")

   // Copied or kept pixels never report a wrapped channel.
   `ASSERT_IMPLIES(a_bypass_no_wrap, clock, reset, rsp_strobe && (rsp_mode_ff != oblend_pkg::MODE_BLEND), !rsp_channel_wrapped, "wrap flag set on a copied pixel")

   // An opaque source comes out fully opaque.
   `ASSERT_IMPLIES(a_source_opaque, clock, reset, rsp_strobe && (rsp_mode_ff == oblend_pkg::MODE_SOURCE), rsp_new_alpha == oblend_pkg::CHAN_MAX, "copied source is not opaque")

endmodule

`default_nettype wire

@@ dv/rgba_over_alpha_blend_tb.sv @@
`timescale 1ns / 1ps

module rgba_over_alpha_blend_tb;

   localparam int unsigned PIPE_LATENCY = 12;
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned CHAN_FULL    = 255;

   // One composited pixel as it leaves the block.
   typedef struct packed {
      logic [7:0] new_red;
      logic [7:0] new_green;
      logic [7:0] new_blue;
      logic [7:0] new_alpha;
      logic       channel_wrapped;
   } blend_result_type;

   // One row of the directed table; the pixel is typed in only where it is obvious.
   typedef struct packed {
      logic [31:0]      word;
      logic [7:0]       dr;
      logic [7:0]       dg;
      logic [7:0]       db;
      logic [7:0]       da;
      logic             typed;
      blend_result_type want;
   } pixel_case_type;

   localparam int unsigned NUM_DIRECTED = 16;

   localparam pixel_case_type DIRECTED [NUM_DIRECTED] = '{
      // Opaque source replaces the destination.
      '{32'hFF112233, 8'h44, 8'h55, 8'h66, 8'h77, 1'b1, '{8'h33, 8'h22, 8'h11, 8'hFF, 1'b0}},
      // Transparent source keeps the destination.
      '{32'h00112233, 8'h44, 8'h55, 8'h66, 8'h77, 1'b1, '{8'h44, 8'h55, 8'h66, 8'h77, 1'b0}},
      '{32'hFFFFFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}},
      '{32'h00000000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}},
      '{32'h00FFFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
      '{32'hFF000000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b0}},
      // Faint source over a faint white: the colour quotients wrap.
      '{32'h01FFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b0, '0},
      '{32'h01000000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
      '{32'h01ABCDEF, 8'h12, 8'h34, 8'h56, 8'h00, 1'b0, '0},
      '{32'hFE80FF00, 8'hFF, 8'h00, 8'h80, 8'hFF, 1'b0, '0},
      '{32'h80FF0000, 8'h00, 8'hFF, 8'h00, 8'h80, 1'b0, '0},
      '{32'h7F123456, 8'hAA, 8'hBB, 8'hCC, 8'h00, 1'b0, '0},
      '{32'h01FFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
      '{32'hFE000000, 8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b0, '0},
      '{32'h55AA55AA, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0, '0},
      '{32'hC3F00F3C, 8'h0F, 8'hF0, 8'h3C, 8'hC3, 1'b0, '0}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_source_word = '0;
   logic [7:0]  req_dest_red = '0;
   logic [7:0]  req_dest_green = '0;
   logic [7:0]  req_dest_blue = '0;
   logic [7:0]  req_dest_alpha = '0;
   logic        rsp_strobe;
   logic [7:0]  rsp_new_red;
   logic [7:0]  rsp_new_green;
   logic [7:0]  rsp_new_blue;
   logic [7:0]  rsp_new_alpha;
   logic        rsp_channel_wrapped;
   logic        csr_we = 1'b0;
   logic [oblend_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [oblend_pkg::SHIFT_W-1:0]   csr_wdata = '0;

   oblend_pkg::shifts_type shifts_now = oblend_pkg::SHIFTS_RESET;
   blend_result_type       pending_pixels [$];
   int unsigned            error_count = 0;
   int unsigned            quiet_cycles = 0;

   rgba_over_alpha_blend DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_source_word     (req_source_word),
      .req_dest_red        (req_dest_red),
      .req_dest_green      (req_dest_green),
      .req_dest_blue       (req_dest_blue),
      .req_dest_alpha      (req_dest_alpha),
      .rsp_strobe          (rsp_strobe),
      .rsp_new_red         (rsp_new_red),
      .rsp_new_green       (rsp_new_green),
      .rsp_new_blue        (rsp_new_blue),
      .rsp_new_alpha       (rsp_new_alpha),
      .rsp_channel_wrapped (rsp_channel_wrapped),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // Free-running clock with a 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // One colour of a partial-alpha blend; a quotient above a byte keeps its low bits.
   function automatic logic [8:0] blend_colour(input int unsigned c, input int unsigned a,
                                               input int unsigned dc, input int unsigned da,
                                               input int unsigned oa);
      int unsigned num;
      int unsigned q;
      num = c * a + ((dc * da) * (CHAN_FULL - a)) / CHAN_FULL;
      q   = num / oa;
      return {q > CHAN_FULL, q[7:0]};
   endfunction

   // Straight-alpha "over" of the source word onto the destination pixel.
   function automatic blend_result_type composite_over(input oblend_pkg::shifts_type s,
                                                       input logic [31:0] w,
                                                       input logic [7:0] dr,
                                                       input logic [7:0] dg,
                                                       input logic [7:0] db,
                                                       input logic [7:0] da);
      int unsigned      r, g, b, a, oa;
      logic [8:0]       cr, cg, cb;
      blend_result_type res;
      r = (w >> s.red) & 32'hFF;
      g = (w >> s.green) & 32'hFF;
      b = (w >> s.blue) & 32'hFF;
      a = (w >> s.alpha) & 32'hFF;
      res = '0;
      if (a == CHAN_FULL) begin
         res = '{r[7:0], g[7:0], b[7:0], a[7:0], 1'b0};
      end else if (a == 0) begin
         res = '{dr, dg, db, da, 1'b0};
      end else begin
         oa = a + (da * (CHAN_FULL - a)) / CHAN_FULL;
         if (oa != 0) begin
            cr = blend_colour(r, a, dr, da, oa);
            cg = blend_colour(g, a, dg, da, oa);
            cb = blend_colour(b, a, db, da, oa);
            res = '{cr[7:0], cg[7:0], cb[7:0], oa[7:0], cr[8] | cg[8] | cb[8]};
         end
      end
      return res;
   endfunction

   // Presents one pixel and holds it until the block takes the transaction.
   task automatic send_pixel(input logic [31:0] w, input logic [7:0] dr, input logic [7:0] dg,
                             input logic [7:0] db, input logic [7:0] da,
                             input blend_result_type want, input int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_source_word <= w;
      req_dest_red    <= dr;
      req_dest_green  <= dg;
      req_dest_blue   <= db;
      req_dest_alpha  <= da;
      do @(posedge clock); while (busy);
      pending_pixels.push_back(want);
   endtask

   task automatic wait_until_drained();
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // A single register write; the caller lowers the write enable afterwards.
   task automatic put_csr(input logic [oblend_pkg::CSR_IDX_W-1:0] idx,
                          input logic [oblend_pkg::SHIFT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Reprograms all four shifts once the pipeline has emptied.
   task automatic write_shifts(input oblend_pkg::shifts_type s);
      wait_until_drained();
      put_csr(oblend_pkg::CSR_RED_SHIFT, s.red);
      put_csr(oblend_pkg::CSR_GREEN_SHIFT, s.green);
      put_csr(oblend_pkg::CSR_BLUE_SHIFT, s.blue);
      put_csr(oblend_pkg::CSR_ALPHA_SHIFT, s.alpha);
      csr_we     <= 1'b0;
      shifts_now = s;
   endtask

   // Mostly shifts inside the word, now and then one that runs off the top.
   function automatic logic [4:0] random_shift();
      return ($urandom_range(7) == 0) ? 5'($urandom_range(31, 25)) : 5'($urandom_range(24, 0));
   endfunction

   // Random pixels, biased towards the alpha corner cases and towards wrapping colours.
   task automatic run_random(input int unsigned count, input int unsigned idle_pct,
                             input int drain_at);
      logic [31:0]      w;
      logic [39:0]      wide;
      logic [7:0]       alpha, dr, dg, db, da;
      blend_result_type want;
      for (int i = 0; i < count; i++) begin
         if (i == drain_at) begin
            // Hold the sender off until every pixel in flight has come back.
            start <= 1'b0;
            wait_until_drained();
         end
         w  = $urandom;
         dr = 8'($urandom);
         dg = 8'($urandom);
         db = 8'($urandom);
         case ($urandom_range(9))
            0: alpha = 8'd0;
            1: alpha = oblend_pkg::CHAN_MAX;
            2: alpha = 8'd1;
            3: alpha = 8'd254;
            default: alpha = 8'($urandom);
         endcase
         case ($urandom_range(5))
            0: da = 8'd0;
            1: da = 8'd255;
            default: da = 8'($urandom);
         endcase
         if ($urandom_range(3) == 0) begin
            w  = '1;
            dr = 8'hFF;
            dg = 8'hFF;
            db = 8'hFF;
         end
         wide = {8'h00, w};
         wide[shifts_now.alpha +: 8] = alpha;
         w = wide[31:0];
         want = composite_over(shifts_now, w, dr, dg, db, da);
         send_pixel(w, dr, dg, db, da, want, idle_pct);
      end
      start <= 1'b0;
   endtask

   // Stimulus: directed table, then random phases under several channel layouts.
   initial begin
      blend_result_type want;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         want = DIRECTED[i].typed ? DIRECTED[i].want
                : composite_over(shifts_now, DIRECTED[i].word, DIRECTED[i].dr,
                                 DIRECTED[i].dg, DIRECTED[i].db, DIRECTED[i].da);
         send_pixel(DIRECTED[i].word, DIRECTED[i].dr, DIRECTED[i].dg, DIRECTED[i].db,
                    DIRECTED[i].da, want, 25);
      end

      run_random(84, 25, -1);
      write_shifts('{5'd24, 5'd16, 5'd8, 5'd0});
      run_random(100, 25, -1);
      write_shifts('{5'd31, 5'd31, 5'd31, 5'd31});
      run_random(60, 57, -1);
      write_shifts('{5'd0, 5'd0, 5'd0, 5'd0});
      run_random(100, 57, 50);
      write_shifts('{random_shift(), random_shift(), random_shift(), random_shift()});
      run_random(120, 0, -1);
      write_shifts('{random_shift(), random_shift(), random_shift(), random_shift()});
      run_random(120, 0, -1);

      wait_until_drained();
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Each strobed pixel is checked against the oldest outstanding transaction.
   always @(posedge clock) begin
      blend_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_pixels.size() == 0) begin
            report_error("result strobed with no transaction outstanding");
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_new_red !== want.new_red)
               report_error($sformatf("new_red got %0h want %0h", rsp_new_red, want.new_red));
            if (rsp_new_green !== want.new_green)
               report_error($sformatf("new_green got %0h want %0h", rsp_new_green,
                                      want.new_green));
            if (rsp_new_blue !== want.new_blue)
               report_error($sformatf("new_blue got %0h want %0h", rsp_new_blue,
                                      want.new_blue));
            if (rsp_new_alpha !== want.new_alpha)
               report_error($sformatf("new_alpha got %0h want %0h", rsp_new_alpha,
                                      want.new_alpha));
            if (rsp_channel_wrapped !== want.channel_wrapped)
               report_error($sformatf("channel_wrapped got %0b want %0b", rsp_channel_wrapped,
                                      want.channel_wrapped));
         end
      end
   end

   // Watchdog: ends the run if neither side moves a transaction for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

@@ rgba_over_alpha_blend.f @@
+incdir+rtl
rtl/oblend_pkg.sv
rtl/oblend_front.sv
rtl/oblend_div.sv
rtl/rgba_over_alpha_blend.sv
dv/rgba_over_alpha_blend_tb.sv
